// ----- sv/deq_pkg.sv -----
package deq_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int OCC_W = 5;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [2:0] OP_PEEK_BACK  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] push_value;
    } t_deq_in;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [OCC_W-1:0]   occupancy;
    } t_deq_out;

    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [AW-1:0]      addr;
        logic signed [31:0] wdata;
        logic [1:0]         status;
        logic [OCC_W-1:0]   occupancy;
    } t_deq_cmd;

endpackage

// ----- sv/double_ended_queue_top.sv -----
// An accepted transaction's result goes through a pending register, then the output.
// Throughput: one transaction per cycle while the input is not stalled, set by the
// single-port ring memory, which performs one read or one write per transaction.
// A result held under output stall blocks input only once a second result waits.
// Synchronous active-low reset clears the head, the count and all valid flags.
// The ring memory is not cleared; entries are read only after being written.
module double_ended_queue_top
    import deq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_deq_in  i_in,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_deq_out o_out
);

    t_deq_cmd           cmd;
    logic               accept;
    logic               pend_adv;
    logic signed [31:0] rd_data;

    logic               r_pend;
    logic               r_pend_rd;
    logic [1:0]         r_pend_status;
    logic [OCC_W-1:0]   r_pend_occ;
    logic               r_out_valid;
    t_deq_out           r_out;

    assign pend_adv   = r_pend && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_pend && !pend_adv;
    assign accept     = i_in_valid && !o_in_stall;

    deq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in),
        .o_cmd    (cmd)
    );

    deq_ram u_ram (
        .i_clk     (i_clk),
        .i_accept  (accept),
        .i_cmd     (cmd),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (accept) begin
            r_pend <= 1'b1;
        end else if (pend_adv) begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_rd     <= cmd.rd_en;
            r_pend_status <= cmd.status;
            r_pend_occ    <= cmd.occupancy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pend_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_adv) begin
            r_out.read_value <= r_pend_rd ? rd_data : '0;
            r_out.status     <= r_pend_status;
            r_out.occupancy  <= r_pend_occ;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_FULL) |-> (o_out.occupancy == OCC_W'(DEPTH)))
        else $error("Full status reported below full occupancy.");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_EMPTY)
            |-> (o_out.occupancy == '0 && o_out.read_value == '0))
        else $error("Empty status reported with stored words or a nonzero value.");

    a_stall_only_when_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_pend && r_out_valid))
        else $error("Input stalled without a waiting result.");

endmodule

// ----- sv/deq_ram.sv -----
module deq_ram
    import deq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_accept,
    input  t_deq_cmd           i_cmd,
    output logic signed [31:0] o_rd_data
);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_accept && i_cmd.wr_en) begin
            r_mem[i_cmd.addr] <= i_cmd.wdata;
        end
        if (i_accept && i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/deq_ctrl.sv -----
module deq_ctrl
    import deq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_deq_in  i_in,
    output t_deq_cmd o_cmd
);

    logic [AW-1:0] r_head;
    logic [AW-1:0] n_head;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    logic          empty;
    logic          full;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;
    logic [CW:0]   tail_sum;
    logic [CW:0]   back_sum;
    logic [AW-1:0] tail_slot;
    logic [AW-1:0] back_slot;

    assign empty    = (r_cnt == '0);
    assign full     = (r_cnt >= CW'(DEPTH));
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign tail_sum = (CW + 1)'(r_head) + (CW + 1)'(r_cnt);
    assign back_sum = tail_sum - (CW + 1)'(1);

    always_comb begin
        tail_slot = tail_sum[AW-1:0];
        back_slot = back_sum[AW-1:0];
        if (tail_sum >= (CW + 1)'(DEPTH)) begin
            tail_slot = AW'(tail_sum - (CW + 1)'(DEPTH));
        end
        if (back_sum >= (CW + 1)'(DEPTH)) begin
            back_slot = AW'(back_sum - (CW + 1)'(DEPTH));
        end
    end

    always_comb begin
        n_head          = r_head;
        n_cnt           = r_cnt;
        o_cmd.wr_en     = 1'b0;
        o_cmd.rd_en     = 1'b0;
        o_cmd.addr      = r_head;
        o_cmd.wdata     = i_in.push_value;
        o_cmd.status    = ST_OK;
        case (i_in.opcode)
            OP_PUSH_FRONT: begin
                if (full) begin
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.wr_en = 1'b1;
                    o_cmd.addr  = head_dec;
                    n_head      = head_dec;
                    n_cnt       = r_cnt + CW'(1);
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.wr_en = 1'b1;
                    o_cmd.addr  = tail_slot;
                    n_cnt       = r_cnt + CW'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    o_cmd.status = ST_EMPTY;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_head      = head_inc;
                    n_cnt       = r_cnt - CW'(1);
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    o_cmd.status = ST_EMPTY;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.addr  = back_slot;
                    n_cnt       = r_cnt - CW'(1);
                end
            end
            OP_PEEK_FRONT: begin
                if (empty) begin
                    o_cmd.status = ST_EMPTY;
                end else begin
                    o_cmd.rd_en = 1'b1;
                end
            end
            OP_PEEK_BACK: begin
                if (empty) begin
                    o_cmd.status = ST_EMPTY;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.addr  = back_slot;
                end
            end
            default: begin
            end
        endcase
        o_cmd.occupancy = OCC_W'(n_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_cnt  <= '0;
        end else if (i_accept) begin
            r_head <= n_head;
            r_cnt  <= n_cnt;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("Element count exceeds the ring depth.");

    a_no_access_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.status != ST_OK) |-> (!o_cmd.wr_en && !o_cmd.rd_en && n_cnt == r_cnt))
        else $error("A rejected transaction touched the ring or the count.");

    a_head_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_in.opcode == OP_POP_FRONT && !empty) |=> (r_head == $past(head_inc)))
        else $error("Head did not advance after a front removal.");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench
    import deq_pkg::*;
();

    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int HOLD_OFF_CYCLES = 40;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_deq_in  i_in;
    logic     o_out_valid;
    logic     i_out_stall;
    t_deq_out o_out;

    logic signed [31:0] ring_words [DEPTH];
    logic [AW-1:0]      ring_head;
    logic [CW-1:0]      ring_count;

    t_deq_out pending_results [$];
    int       fail_count;
    bit       sender_idle;
    bit       receiver_idle;
    int       hold_off_request;
    bit       leaning_full;

    double_ended_queue_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_deq_out predict_deque_op(input t_deq_in item);
        t_deq_out      res;
        logic [AW-1:0] tail;
        res.read_value = '0;
        res.status     = ST_OK;
        tail           = AW'(ring_head + ring_count - 1);
        case (item.opcode)
            OP_PUSH_FRONT: begin
                if (ring_count == CW'(DEPTH)) begin
                    res.status = ST_FULL;
                end else begin
                    ring_head = ring_head - 1'b1;
                    ring_words[ring_head] = item.push_value;
                    ring_count++;
                end
            end
            OP_PUSH_BACK: begin
                if (ring_count == CW'(DEPTH)) begin
                    res.status = ST_FULL;
                end else begin
                    ring_words[AW'(ring_head + ring_count)] = item.push_value;
                    ring_count++;
                end
            end
            OP_POP_FRONT: begin
                if (ring_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.read_value = ring_words[ring_head];
                    ring_head = ring_head + 1'b1;
                    ring_count--;
                end
            end
            OP_POP_BACK: begin
                if (ring_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.read_value = ring_words[tail];
                    ring_count--;
                end
            end
            OP_PEEK_FRONT: begin
                if (ring_count == 0) res.status = ST_EMPTY;
                else res.read_value = ring_words[ring_head];
            end
            OP_PEEK_BACK: begin
                if (ring_count == 0) res.status = ST_EMPTY;
                else res.read_value = ring_words[tail];
            end
            default: begin
            end
        endcase
        res.occupancy = OCC_W'(ring_count);
        return res;
    endfunction

    // Called and returns at a falling edge; valid stays high after the transaction.
    task automatic send_op(input logic [2:0] op, input logic signed [31:0] value);
        t_deq_in item;
        int      gap;
        item.opcode     = op;
        item.push_value = value;
        gap = sender_idle ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_results.push_back(predict_deque_op(item));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic test_empty_ops();
        send_op(OP_POP_FRONT, 32'sd5);
        send_op(OP_POP_BACK, -32'sd1);
        send_op(OP_PEEK_FRONT, 32'sd0);
        send_op(OP_PEEK_BACK, 32'sh7FFFFFFF);
        send_op(OP_SPARE_LO, 32'sh80000000);
        send_op(OP_SPARE_HI, -32'sd1);
    endtask

    task automatic test_single_word();
        send_op(OP_PUSH_BACK, 32'sh7FFFFFFF);
        send_op(OP_POP_FRONT, 32'sd0);
        send_op(OP_PUSH_FRONT, 32'sh80000000);
        send_op(OP_POP_BACK, -32'sd1);
    endtask

    task automatic test_fill_to_full();
        logic signed [31:0] value;
        for (int k = 0; k < DEPTH; k++) begin
            if (k == 0) value = 32'sh7FFFFFFF;
            else if (k == 1) value = 32'sh80000000;
            else if (k == 2) value = -32'sd1;
            else value = $urandom;
            send_op(k[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, value);
        end
        send_op(OP_PUSH_FRONT, 32'sd11);
        send_op(OP_PUSH_BACK, 32'sd22);
        send_op(OP_PEEK_FRONT, 32'sd0);
        send_op(OP_PEEK_BACK, 32'sd0);
    endtask

    task automatic test_random_traffic(input int count);
        int          r;
        int          push_share;
        int          rest;
        logic [2:0]  op;
        for (int n = 0; n < count; n++) begin
            if (ring_count == CW'(DEPTH)) leaning_full = 1'b0;
            else if (ring_count == 0) leaning_full = 1'b1;
            push_share = leaning_full ? 65 : 25;
            r = $urandom_range(0, 99);
            if (r < 3) begin
                op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
            end else if (r < 3 + push_share) begin
                op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            end else begin
                rest = r - 3 - push_share;
                if (rest < (97 - push_share) * 3 / 4)
                    op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
                else
                    op = $urandom_range(0, 1) ? OP_PEEK_BACK : OP_PEEK_FRONT;
            end
            send_op(op, $urandom);
        end
    endtask

    task automatic test_backpressure();
        bit saved_idle;
        saved_idle       = sender_idle;
        sender_idle      = 1'b0;
        hold_off_request = HOLD_OFF_CYCLES;
        test_random_traffic(40);
        sender_idle      = saved_idle;
    endtask

    initial begin
        int gap;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            gap = receiver_idle ? $urandom_range(0, 4) : 0;
            if (hold_off_request != 0) begin
                gap += hold_off_request;
                hold_off_request = 0;
            end
            if (gap != 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        t_deq_out expected;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no transaction outstanding");
                fail_count++;
            end else begin
                expected = pending_results.pop_front();
                if (o_out.read_value !== expected.read_value) begin
                    $error("read_value expected %0d actual %0d",
                           expected.read_value, o_out.read_value);
                    fail_count++;
                end
                if (o_out.status !== expected.status) begin
                    $error("status expected %0d actual %0d", expected.status, o_out.status);
                    fail_count++;
                end
                if (o_out.occupancy !== expected.occupancy) begin
                    $error("occupancy expected %0d actual %0d",
                           expected.occupancy, o_out.occupancy);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        fail_count       = 0;
        hold_off_request = 0;
        sender_idle      = 1'b1;
        receiver_idle    = 1'b1;
        leaning_full     = 1'b1;
        ring_head        = '0;
        ring_count       = '0;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_in             = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_ops();
        test_single_word();
        test_fill_to_full();
        wait_drained();
        test_random_traffic(500);
        test_backpressure();
        wait_drained();
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        test_random_traffic(150);
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        test_random_traffic(450);
        wait_drained();
        repeat (4) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
